FILE: src/assert_macros.svh
// Assertion macros used by sfk_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define FK_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

`define FK_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: src/sfk_pkg.sv
`default_nettype none
package sfk_pkg;

   localparam int MAX_JOINTS   = 32;
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int PI_Q13       = 25736;
   localparam int TWO_PI_Q13   = 51472;
   localparam int HALF_PI_Q13  = 12868;
   localparam int ONE_Q14      = 16384;
   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

   typedef enum logic {OP_JOINT, OP_CLEAR} op_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CORDIC, ST_TRIG, ST_MUL1, ST_MUL2, ST_MT, ST_PROD, ST_SUM
   } fsm_type;

   typedef struct packed {
      op_type           op;
      logic             par_ok;
      logic [4:0]       joint;
      logic [4:0]       parent;
      logic [2:0][15:0] ang;
      logic [2:0][31:0] ofs;
   } cmd_type;

   typedef struct packed {
      logic [8:0][15:0] rot;
      logic [2:0][31:0] pos;
   } row_type;

   function automatic logic signed [19:0] atan_step(input logic [STEP_W-1:0] i);
      logic signed [19:0] r;
      case (i)
         4'd0:    r = 20'sd51472;
         4'd1:    r = 20'sd30385;
         4'd2:    r = 20'sd16054;
         4'd3:    r = 20'sd8150;
         4'd4:    r = 20'sd4091;
         4'd5:    r = 20'sd2047;
         4'd6:    r = 20'sd1024;
         4'd7:    r = 20'sd512;
         4'd8:    r = 20'sd256;
         4'd9:    r = 20'sd128;
         4'd10:   r = 20'sd64;
         4'd11:   r = 20'sd32;
         4'd12:   r = 20'sd16;
         4'd13:   r = 20'sd8;
         4'd14:   r = 20'sd4;
         4'd15:   r = 20'sd2;
         default: r = 20'sd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: src/sfk_front.sv
`default_nettype none
module sfk_front
   import sfk_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic         req_kind,
   input  wire logic [4:0]   req_joint_index,
   input  wire logic [4:0]   req_parent_index,
   input  wire logic [15:0]  req_angle_x,
   input  wire logic [15:0]  req_angle_y,
   input  wire logic [15:0]  req_angle_z,
   input  wire logic [31:0]  req_offset_x,
   input  wire logic [31:0]  req_offset_y,
   input  wire logic [31:0]  req_offset_z,
   output logic              cmd_valid,
   output cmd_type           cmd,
   input  wire logic         cmd_pop
);

   cmd_type    buf_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, keep;
   cmd_type    item;

   always_comb begin
      keep          = req_kind || (32'(req_joint_index) < MAX_JOINTS);
      item.op       = req_kind ? OP_CLEAR : OP_JOINT;
      item.par_ok   = (req_joint_index != 5'd0) && (32'(req_parent_index) < MAX_JOINTS);
      item.joint    = req_joint_index;
      item.parent   = req_parent_index;
      item.ang      = {req_angle_z, req_angle_y, req_angle_x};
      item.ofs      = {req_offset_z, req_offset_y, req_offset_x};
      req_ready     = (count_ff != 2'd2);
      push          = req_valid && req_ready && keep;
      wr_ptr_in     = wr_ptr_ff ^ push;
      rd_ptr_in     = rd_ptr_ff ^ cmd_pop;
      count_in      = count_ff + 2'(push) - 2'(cmd_pop);
      cmd_valid     = (count_ff != 2'd0);
      cmd           = buf_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= item;
      end
   end

endmodule
`default_nettype wire

FILE: src/sfk_back.sv
`default_nettype none
`include "assert_macros.svh"
module sfk_back
   import sfk_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         cmd_valid,
   input  wire cmd_type      cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [4:0]        rsp_out_joint,
   output logic [31:0]       rsp_pos_x,
   output logic [31:0]       rsp_pos_y,
   output logic [31:0]       rsp_pos_z,
   output logic              rsp_overflow
);

   fsm_type                 state_ff, state_in;
   logic [STEP_W-1:0]       cnt_ff;
   cmd_type                 cmd_ff;
   logic [MAX_JOINTS-1:0]   valid_ff;
   row_type                 mem [MAX_JOINTS];
   row_type                 rd_ff;
   logic                    par_ok_ff;
   logic signed [32:0]      x_ff [3];
   logic signed [32:0]      y_ff [3];
   logic signed [19:0]      z_ff [3];
   logic                    flip_ff [3];
   logic signed [15:0]      s_ff [3];
   logic signed [15:0]      c_ff [3];
   logic signed [31:0]      p_ff [10];
   logic signed [47:0]      q_ff [4];
   logic signed [15:0]      m_ff [9];
   logic signed [15:0]      gp_ff [9];
   logic signed [31:0]      pp_ff [3];
   logic signed [31:0]      rp_ff [27];
   logic signed [47:0]      pq_ff [9];
   logic                    rsp_valid_ff;
   logic [4:0]              out_joint_ff;
   logic [2:0][31:0]        out_pos_ff;
   logic                    out_ovf_ff;

   logic                    load_out, mem_we, clear;
   logic signed [32:0]      x_in [3];
   logic signed [32:0]      y_in [3];
   logic signed [19:0]      z_in [3];
   logic signed [19:0]      z0 [3];
   logic                    flip0 [3];
   logic signed [15:0]      s_in [3];
   logic signed [15:0]      c_in [3];
   logic signed [17:0]      a_red [3];
   logic signed [16:0]      cq [3];
   logic signed [16:0]      sq [3];
   logic signed [47:0]      t [9];
   logic signed [19:0]      tr [9];
   logic signed [15:0]      m_in [9];
   logic signed [33:0]      rs [9];
   logic signed [19:0]      rr [9];
   row_type                 new_row;
   logic signed [49:0]      ps [3];
   logic signed [36:0]      pf [3];
   logic [2:0]              ovf;

   always_comb begin
      state_in = state_ff;
      cmd_pop  = 1'b0;
      load_out = 1'b0;
      mem_we   = 1'b0;
      clear    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.op == OP_CLEAR) begin
                  clear = 1'b1;
               end else begin
                  state_in = ST_CORDIC;
               end
            end
         end
         ST_CORDIC: begin
            if (cnt_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_TRIG;
            end
         end
         ST_TRIG: state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_MT;
         ST_MT:   state_in = ST_PROD;
         ST_PROD: state_in = ST_SUM;
         ST_SUM: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               mem_we   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         a_red[l] = 18'($signed(cmd.ang[l]));
         if (a_red[l] > 18'sd25736) begin
            a_red[l] = a_red[l] - 18'(TWO_PI_Q13);
         end else if (a_red[l] < -18'sd25736) begin
            a_red[l] = a_red[l] + 18'(TWO_PI_Q13);
         end
         flip0[l] = 1'b0;
         if (a_red[l] > 18'sd12868) begin
            a_red[l] = a_red[l] - 18'(PI_Q13);
            flip0[l] = 1'b1;
         end else if (a_red[l] < -18'sd12868) begin
            a_red[l] = a_red[l] + 18'(PI_Q13);
            flip0[l] = 1'b1;
         end
         z0[l] = 20'(a_red[l]) <<< 3;

         if (z_ff[l] >= 0) begin
            x_in[l] = x_ff[l] - (y_ff[l] >>> cnt_ff);
            y_in[l] = y_ff[l] + (x_ff[l] >>> cnt_ff);
            z_in[l] = z_ff[l] - atan_step(cnt_ff);
         end else begin
            x_in[l] = x_ff[l] + (y_ff[l] >>> cnt_ff);
            y_in[l] = y_ff[l] - (x_ff[l] >>> cnt_ff);
            z_in[l] = z_ff[l] + atan_step(cnt_ff);
         end

         cq[l] = 17'((x_ff[l] + 33'sd32768) >>> 16);
         sq[l] = 17'((y_ff[l] + 33'sd32768) >>> 16);
         if (cq[l] > 17'sd16384) cq[l] = 17'sd16384;
         if (cq[l] < -17'sd16384) cq[l] = -17'sd16384;
         if (sq[l] > 17'sd16384) sq[l] = 17'sd16384;
         if (sq[l] < -17'sd16384) sq[l] = -17'sd16384;
         if (flip_ff[l]) begin
            cq[l] = -cq[l];
            sq[l] = -sq[l];
         end
         c_in[l] = 16'(cq[l]);
         s_in[l] = 16'(sq[l]);
      end
   end

   always_comb begin
      t[0] = 48'(p_ff[0]) <<< 14;
      t[1] = -(48'(p_ff[1]) <<< 14);
      t[2] = 48'(s_ff[1]) <<< 28;
      t[3] = q_ff[0] + (48'(p_ff[3]) <<< 14);
      t[4] = (48'(p_ff[4]) <<< 14) - q_ff[1];
      t[5] = -(48'(p_ff[5]) <<< 14);
      t[6] = (48'(p_ff[7]) <<< 14) - q_ff[2];
      t[7] = (48'(p_ff[8]) <<< 14) + q_ff[3];
      t[8] = 48'(p_ff[9]) <<< 14;
      for (int k = 0; k < 9; k++) begin
         tr[k] = 20'((t[k] + 48'sd134217728) >>> 28);
         if (tr[k] > 20'sd32767) m_in[k] = 16'sh7fff;
         else if (tr[k] < -20'sd32768) m_in[k] = 16'sh8000;
         else m_in[k] = 16'(tr[k]);
      end
   end

   always_comb begin
      new_row = '0;
      for (int k = 0; k < 9; k++) begin
         rs[k] = 34'(rp_ff[k*3]) + 34'(rp_ff[k*3+1]) + 34'(rp_ff[k*3+2]);
         rr[k] = 20'((rs[k] + 34'sd8192) >>> 14);
         if (rr[k] > 20'sd32767) new_row.rot[k] = 16'h7fff;
         else if (rr[k] < -20'sd32768) new_row.rot[k] = 16'h8000;
         else new_row.rot[k] = 16'(rr[k]);
      end
      for (int c = 0; c < 3; c++) begin
         ps[c] = 50'(pq_ff[c*3]) + 50'(pq_ff[c*3+1]) + 50'(pq_ff[c*3+2]);
         pf[c] = 37'((ps[c] + 50'sd8192) >>> 14) + 37'(pp_ff[c]);
         ovf[c] = 1'b1;
         if (pf[c] > 37'sd2147483647) new_row.pos[c] = 32'h7fffffff;
         else if (pf[c] < -37'sd2147483648) new_row.pos[c] = 32'h80000000;
         else begin
            new_row.pos[c] = 32'(pf[c]);
            ovf[c] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= (state_ff == ST_CORDIC) ? cnt_ff + 1'b1 : '0;
         if (clear) begin
            valid_ff <= '0;
         end else if (mem_we) begin
            valid_ff[cmd_ff.joint] <= 1'b1;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cmd_ff.joint] <= new_row;
      end
      if (cmd_pop) begin
         rd_ff     <= mem[cmd.parent];
         par_ok_ff <= cmd.par_ok && valid_ff[cmd.parent];
         cmd_ff    <= cmd;
         for (int l = 0; l < 3; l++) begin
            x_ff[l]    <= CORDIC_GAIN;
            y_ff[l]    <= '0;
            z_ff[l]    <= z0[l];
            flip_ff[l] <= flip0[l];
         end
      end
      if (state_ff == ST_CORDIC) begin
         for (int l = 0; l < 3; l++) begin
            x_ff[l] <= x_in[l];
            y_ff[l] <= y_in[l];
            z_ff[l] <= z_in[l];
         end
      end
      if (state_ff == ST_TRIG) begin
         for (int l = 0; l < 3; l++) begin
            s_ff[l] <= s_in[l];
            c_ff[l] <= c_in[l];
         end
         for (int k = 0; k < 9; k++) begin
            gp_ff[k] <= par_ok_ff ? $signed(rd_ff.rot[k])
                                  : ((k % 4 == 0) ? 16'sd16384 : 16'sd0);
         end
         for (int c = 0; c < 3; c++) begin
            pp_ff[c] <= par_ok_ff ? $signed(rd_ff.pos[c]) : 32'sd0;
         end
      end
      if (state_ff == ST_MUL1) begin
         p_ff[0] <= c_ff[1] * c_ff[2];
         p_ff[1] <= c_ff[1] * s_ff[2];
         p_ff[2] <= s_ff[0] * s_ff[1];
         p_ff[3] <= c_ff[0] * s_ff[2];
         p_ff[4] <= c_ff[0] * c_ff[2];
         p_ff[5] <= c_ff[1] * s_ff[0];
         p_ff[6] <= c_ff[0] * s_ff[1];
         p_ff[7] <= s_ff[0] * s_ff[2];
         p_ff[8] <= s_ff[0] * c_ff[2];
         p_ff[9] <= c_ff[0] * c_ff[1];
      end
      if (state_ff == ST_MUL2) begin
         q_ff[0] <= 48'(p_ff[2]) * 48'(c_ff[2]);
         q_ff[1] <= 48'(p_ff[2]) * 48'(s_ff[2]);
         q_ff[2] <= 48'(p_ff[6]) * 48'(c_ff[2]);
         q_ff[3] <= 48'(p_ff[6]) * 48'(s_ff[2]);
      end
      if (state_ff == ST_MT) begin
         for (int k = 0; k < 9; k++) begin
            m_ff[k] <= m_in[k];
         end
      end
      if (state_ff == ST_PROD) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               for (int k = 0; k < 3; k++) begin
                  rp_ff[(r*3+c)*3+k] <= m_ff[k*3+r] * gp_ff[k*3+c];
                  pq_ff[c*3+k] <= 48'($signed(cmd_ff.ofs[k])) * 48'(gp_ff[k*3+c]);
               end
            end
         end
      end
      if (load_out) begin
         out_joint_ff <= cmd_ff.joint;
         out_pos_ff   <= new_row.pos;
         out_ovf_ff   <= |ovf;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_joint = out_joint_ff;
   assign rsp_pos_x     = out_pos_ff[0];
   assign rsp_pos_y     = out_pos_ff[1];
   assign rsp_pos_z     = out_pos_ff[2];
   assign rsp_overflow  = out_ovf_ff;

   `FK_ASSERT_IMP(a_pop_idle, clock, reset, cmd_pop, state_ff == ST_IDLE)
   `FK_ASSERT_NXT(a_clear_valid, clock, reset, clear, valid_ff == '0)
   `FK_ASSERT_IMP(a_rsp_from_sum, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_SUM))

endmodule
`default_nettype wire

FILE: src/skeleton_forward_kinematics.sv
`default_nettype none
// Forward kinematics of a joint hierarchy. Items enter on the req_ channel with
// valid and ready; each joint item gives one result on the rsp_ channel, with the
// global position of that joint. Clear items give no result. Items must arrive
// parent before child. A two-entry queue sits behind the input, so req_ready
// stays high while the engine works until two items wait. The engine handles
// one item at a time: a joint item passes from leaving the queue to its result
// through the sixteen-step sine and cosine iteration and six further stages of
// products, sums and the store write, and the next item leaves the queue only
// once the engine is idle again.
// When the receiver stalls, the result waits in the output register and the
// engine holds its next result until that one is taken; the queue keeps taking
// items until full. Reset empties the queue and the output register and marks
// every joint as holding an identity rotation and zero position.
module skeleton_forward_kinematics
   import sfk_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic         req_kind,
   input  wire logic [4:0]   req_joint_index,
   input  wire logic [4:0]   req_parent_index,
   input  wire logic [15:0]  req_angle_x,
   input  wire logic [15:0]  req_angle_y,
   input  wire logic [15:0]  req_angle_z,
   input  wire logic [31:0]  req_offset_x,
   input  wire logic [31:0]  req_offset_y,
   input  wire logic [31:0]  req_offset_z,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [4:0]        rsp_out_joint,
   output logic [31:0]       rsp_pos_x,
   output logic [31:0]       rsp_pos_y,
   output logic [31:0]       rsp_pos_z,
   output logic              rsp_overflow
);

   logic    cmd_valid, cmd_pop;
   cmd_type cmd;

   sfk_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_joint_index  (req_joint_index),
      .req_parent_index (req_parent_index),
      .req_angle_x      (req_angle_x),
      .req_angle_y      (req_angle_y),
      .req_angle_z      (req_angle_z),
      .req_offset_x     (req_offset_x),
      .req_offset_y     (req_offset_y),
      .req_offset_z     (req_offset_z),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop)
   );

   sfk_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_joint (rsp_out_joint),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_pos_z     (rsp_pos_z),
      .rsp_overflow  (rsp_overflow)
   );

endmodule
`default_nettype wire
